FILE: rtl/core/srecord_loader_macros.svh
// assertion macros for the s-record loader checker
`ifndef SRECORD_LOADER_MACROS_SVH
`define SRECORD_LOADER_MACROS_SVH

// checked only outside reset
`define SRL_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("srecord_loader check failed");

// checked during reset too
`define SRL_ASSERT_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("srecord_loader reset check failed");

`endif

FILE: rtl/core/srl_pkg.sv
// shared types, codes and helpers of the s-record loader
package srl_pkg;

    localparam int ADDR_W     = 18;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [ADDR_W-1:0] LOWEST_RESET = 18'h1fffe;

    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_2  = 8'h32;
    localparam logic [7:0] CH_3  = 8'h33;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_8  = 8'h38;
    localparam logic [7:0] CH_9  = 8'h39;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_FORMAT = 2'd1;
    localparam logic [1:0] ERR_BAD_RECORD = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE  = 2'd3;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SKIP,
        PH_DONE,
        PH_HALT
    } phase_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] lowest;
        logic [ADDR_W-1:0] image_end;
        logic [1:0]        error_code;
        logic              final_res;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

    // {valid, value} of one hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = '0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, c[3:0]};
            end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
                r = {1'b1, 4'(c[3:0] + 4'd9)};
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/srecord_loader.sv
// s-record loader top level
//
//   channel  direction  words                      handshake
//   s_       in         ch, last                   s_valid / s_ready
//   m_       out        one result per word        m_valid / m_ready
//   cfg_     in         lowest_initial             cfg_wr_en, no wait
//
// one character per cycle while s_ready is high; the parser state updates in the accepting cycle
// and its 0, 1 or 2 results enter a 4-word queue that drives the m_ ports
// s_ready drops only while the queue has fewer than two free words
// reset is synchronous and empties the queue; no clearing pass
// after a summary or error word, characters are taken and give nothing
module srecord_loader import srl_pkg::*; #(
    parameter int IMAGE_BYTES = 262144
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_ch,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [ADDR_W-1:0] m_address,
    output logic [7:0]        m_data_byte,
    output logic [ADDR_W-1:0] m_lowest,
    output logic [ADDR_W-1:0] m_image_end,
    output logic [1:0]        m_error_code,
    output logic              m_final_res,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data
);

    push_t   push;
    result_t head;
    logic    room;

    assign s_ready = room;

    srl_parser #(
        .IMAGE_BYTES(IMAGE_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (s_valid && s_ready),
        .ch         (s_ch),
        .last       (s_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .push       (push)
    );

    srl_outq u_outq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .room   (room),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .head   (head)
    );

    assign m_kind       = head.kind;
    assign m_address    = head.address;
    assign m_data_byte  = head.data_byte;
    assign m_lowest     = head.lowest;
    assign m_image_end  = head.image_end;
    assign m_error_code = head.error_code;
    assign m_final_res  = head.final_res;

endmodule

FILE: rtl/core/srl_parser.sv
// per-character record parser: state registers and result generation
module srl_parser import srl_pkg::*; #(
    parameter int IMAGE_BYTES = 262144
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        ch,
    input  logic              last,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    output push_t             push
);

    phase_t            phase_reg, phase_next, phase_mid;
    logic [2:0]        alen_reg, alen_next;
    logic [3:0]        hi_reg, hi_next;
    logic              nib_reg, nib_next;
    logic [2:0]        abl_reg, abl_next;
    logic [7:0]        dl_reg, dl_next;
    logic [31:0]       acc_reg, acc_next;
    logic [ADDR_W-1:0] lowest_reg, lowest_next;
    logic [ADDR_W-1:0] end_reg, end_next;

    logic [4:0]        hex;
    logic              hex_ok;
    logic              byte_done;
    logic [7:0]        byte_val;
    logic [31:0]       acc_shift;
    logic [2:0]        abl_dec;
    logic [7:0]        dl_count;
    logic              big;
    logic              ev_fail1, ev_fail2, ev_fail3, ev_stop, ev_write, ev_finish;
    logic [ADDR_W-1:0] acc_fin;
    logic [ADDR_W-1:0] lowest_step, end_step;

    logic              main_emit, tail_emit;
    result_t           main_res, tail_res;

    // decode of the current character against the current phase
    always_comb begin
        hex       = hex_decode(ch);
        hex_ok    = hex[4];
        byte_done = hex_ok && nib_reg;
        byte_val  = {hi_reg, hex[3:0]};
        acc_shift = {acc_reg[23:0], byte_val};
        abl_dec   = abl_reg - 3'd1;
        dl_count  = (byte_val > {5'b0, alen_reg}) ? byte_val - 8'd1 - {5'b0, alen_reg} : '0;
        big       = ({1'b0, acc_shift} + {25'b0, dl_reg}) >= 33'(IMAGE_BYTES);
        ev_fail1  = 1'b0;
        ev_fail2  = 1'b0;
        ev_fail3  = 1'b0;
        ev_stop   = 1'b0;
        ev_write  = 1'b0;
        ev_finish = 1'b0;
        acc_fin   = acc_shift[ADDR_W-1:0];
        phase_mid = phase_reg;
        unique case (phase_reg)
            PH_LINE: begin
                if (ch != CH_NL) begin
                    if (ch != CH_S) begin
                        ev_fail1  = 1'b1;
                        phase_mid = PH_HALT;
                    end else begin
                        phase_mid = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                if (ch == CH_7 || ch == CH_8 || ch == CH_9) begin
                    ev_stop   = 1'b1;
                    phase_mid = PH_DONE;
                end else if (ch == CH_NL) begin
                    ev_fail2  = 1'b1;
                    phase_mid = PH_HALT;
                end else begin
                    phase_mid = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (!hex_ok) begin
                    ev_fail2  = 1'b1;
                    phase_mid = PH_HALT;
                end else if (nib_reg) begin
                    phase_mid = (alen_reg == 3'd0) ? PH_SKIP : PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (!hex_ok) begin
                    ev_fail2  = 1'b1;
                    phase_mid = PH_HALT;
                end else if (byte_done && abl_dec == 3'd0) begin
                    if (big) begin
                        ev_fail3  = 1'b1;
                        phase_mid = PH_HALT;
                    end else if (dl_reg == 8'd0) begin
                        ev_finish = 1'b1;
                        phase_mid = PH_SKIP;
                    end else begin
                        phase_mid = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                acc_fin = acc_reg[ADDR_W-1:0] + 18'd1;
                if (!hex_ok) begin
                    ev_fail2  = 1'b1;
                    phase_mid = PH_HALT;
                end else if (byte_done) begin
                    ev_write = 1'b1;
                    if (dl_reg == 8'd1) begin
                        ev_finish = 1'b1;
                        phase_mid = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (ch == CH_NL) begin
                    phase_mid = PH_LINE;
                end
            end
            PH_DONE, PH_HALT: begin
                phase_mid = phase_reg;
            end
        endcase
        lowest_step = (ev_write && acc_reg < {14'b0, lowest_reg}) ?
                      acc_reg[ADDR_W-1:0] : lowest_reg;
        end_step    = (ev_finish && acc_fin > end_reg) ? acc_fin : end_reg;
    end

    // next state
    always_comb begin
        phase_next  = phase_mid;
        alen_next   = alen_reg;
        hi_next     = hi_reg;
        nib_next    = nib_reg;
        abl_next    = abl_reg;
        dl_next     = dl_reg;
        acc_next    = acc_reg;
        unique case (phase_reg)
            PH_TYPE: begin
                nib_next  = 1'b0;
                alen_next = (ch == CH_1) ? 3'd2 : (ch == CH_2) ? 3'd3 :
                            (ch == CH_3) ? 3'd4 : 3'd0;
            end
            PH_COUNT, PH_ADDR, PH_DATA: begin
                if (hex_ok) begin
                    if (!nib_reg) begin
                        hi_next  = hex[3:0];
                        nib_next = 1'b1;
                    end else begin
                        nib_next = 1'b0;
                        if (phase_reg == PH_COUNT) begin
                            dl_next  = dl_count;
                            abl_next = alen_reg;
                            acc_next = '0;
                        end else if (phase_reg == PH_ADDR) begin
                            acc_next = acc_shift;
                            abl_next = abl_dec;
                        end else begin
                            acc_next = acc_reg + 32'd1;
                            dl_next  = dl_reg - 8'd1;
                        end
                    end
                end
            end
            PH_LINE, PH_SKIP, PH_DONE, PH_HALT: begin
                nib_next = nib_reg;
            end
        endcase
        if (last && phase_mid != PH_DONE && phase_mid != PH_HALT) begin
            phase_next = (phase_mid == PH_LINE || phase_mid == PH_SKIP) ? PH_DONE : PH_HALT;
        end
        lowest_next = cfg_wr_en ? cfg_wr_data : (step_en ? lowest_step : lowest_reg);
        end_next    = step_en ? end_step : end_reg;
    end

    // results of this character
    always_comb begin
        main_emit = ev_fail1 || ev_fail2 || ev_fail3 || ev_stop || ev_write;
        tail_emit = last && phase_mid != PH_DONE && phase_mid != PH_HALT;

        main_res            = '0;
        main_res.lowest     = lowest_step;
        main_res.image_end  = end_step;
        if (ev_write) begin
            main_res.kind      = KIND_WRITE;
            main_res.address   = acc_reg[ADDR_W-1:0];
            main_res.data_byte = byte_val;
            main_res.image_end = end_reg;
        end else if (ev_stop) begin
            main_res.kind = KIND_SUMMARY;
        end else begin
            main_res.kind       = KIND_ERROR;
            main_res.error_code = ev_fail1 ? ERR_BAD_FORMAT :
                                  ev_fail3 ? ERR_TOO_LARGE : ERR_BAD_RECORD;
        end

        tail_res           = '0;
        tail_res.lowest    = lowest_step;
        tail_res.image_end = end_step;
        tail_res.final_res = 1'b1;
        if (phase_mid == PH_LINE || phase_mid == PH_SKIP) begin
            tail_res.kind = KIND_SUMMARY;
        end else begin
            tail_res.kind       = KIND_ERROR;
            tail_res.error_code = ERR_BAD_RECORD;
        end

        push    = '0;
        push.r1 = tail_res;
        if (main_emit) begin
            push.r0           = main_res;
            push.r0.final_res = !tail_emit;
        end else begin
            push.r0 = tail_res;
        end
        if (step_en) begin
            push.num = 2'(main_emit) + 2'(tail_emit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LINE;
            alen_reg   <= '0;
            hi_reg     <= '0;
            nib_reg    <= 1'b0;
            abl_reg    <= '0;
            dl_reg     <= '0;
            acc_reg    <= '0;
            lowest_reg <= LOWEST_RESET;
            end_reg    <= '0;
        end else begin
            if (step_en) begin
                phase_reg <= phase_next;
                alen_reg  <= alen_next;
                hi_reg    <= hi_next;
                nib_reg   <= nib_next;
                abl_reg   <= abl_next;
                dl_reg    <= dl_next;
                acc_reg   <= acc_next;
            end
            lowest_reg <= lowest_next;
            end_reg    <= end_next;
        end
    end

endmodule

FILE: rtl/core/srl_outq.sv
// result queue: takes up to two words a cycle, hands out one while m_ready is high
module srl_outq import srl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t head
);

    result_t               q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign m_valid  = cnt_reg != '0;
    assign room     = cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
    assign head     = q_mem[rd_ptr_reg];
    assign pop      = m_valid && m_ready;
    assign cnt_next = cnt_reg + OUTQ_CNT_W'(push.num) - OUTQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(push.num);
            rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            q_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2) begin
            q_mem[wr_ptr_reg + OUTQ_PTR_W'(1)] <= push.r1;
        end
    end

endmodule

FILE: rtl/core/srl_checker.sv
// port checker for the s-record loader, bound to the top level
`include "srecord_loader_macros.svh"

module srl_checker import srl_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_kind,
    input logic [ADDR_W-1:0] m_address,
    input logic [7:0]        m_data_byte,
    input logic [ADDR_W-1:0] m_lowest,
    input logic [ADDR_W-1:0] m_image_end,
    input logic [1:0]        m_error_code,
    input logic              m_final_res
);

    result_t out_word;
    logic    non_write;

    assign out_word  = {m_kind, m_address, m_data_byte, m_lowest, m_image_end, m_error_code,
                        m_final_res};
    assign non_write = m_valid && m_kind != KIND_WRITE;

    `SRL_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)
    `SRL_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(out_word))
    `SRL_ASSERT(a_err_code, m_valid |-> ((m_kind == KIND_ERROR) == (m_error_code != ERR_NONE)))
    `SRL_ASSERT(a_non_write_zero, non_write |-> m_address == '0 && m_data_byte == '0)
    `SRL_ASSERT(a_non_write_final, non_write |-> m_final_res)

endmodule

bind srecord_loader srl_checker u_srl_checker (.*);
